// ===== design/mrhf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrhf_pkg
// shared types and constants of the ramp / hold / fade channel table
// ----------------------------------------------------------------------------
package mrhf_pkg;

   localparam int DEF_NUM_CHANNELS = 16;
   localparam int MAX_RESULTS      = 16;

   localparam logic [15:0] FADE_MS_RESET = 16'd500;
   localparam logic [16:0] ONE_Q16       = 17'h10000;
   // smoothstep factor 3 - 2 * p, scaled by 2^16
   localparam logic [17:0] SMOOTH_K      = 18'd196608;

   localparam logic [1:0] KIND_SET         = 2'd0;
   localparam logic [1:0] KIND_RELEASE_ONE = 2'd1;
   localparam logic [1:0] KIND_RELEASE_ALL = 2'd2;
   localparam logic [1:0] KIND_SAMPLE      = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_CALC,
      S_DIV,
      S_SQ,
      S_SM,
      S_MUL,
      S_ADD,
      S_EMIT,
      S_NEXT,
      S_FINAL
   } state_type;

   typedef struct packed {
      logic [31:0] ramp_from;
      logic [31:0] ramp_to;
      logic [31:0] ramp_start;
      logic [23:0] ramp_len;
      logic        hold_on;
      logic [23:0] hold_len;
      logic [31:0] rest_value;
      logic [1:0]  chan_mode;
      logic        fading;
      logic [31:0] fade_start;
      logic [31:0] fade_from;
      logic        done_once;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [23:0] dividend;
      logic [23:0] divisor;
   } div_req_type;

endpackage

// ===== design/mrhf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrhf_div
// restoring divider for progress, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mrhf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mrhf_pkg::div_req_type div_req,
   output logic                 div_done,
   output logic [15:0]          quotient
);
   import mrhf_pkg::*;

   logic [23:0] rem_ff,  rem_in;
   logic [23:0] dsr_ff,  dsr_in;
   logic [15:0] quo_ff,  quo_in;
   logic [4:0]  cnt_ff,  cnt_in;
   logic        done_ff, done_in;
   logic [24:0] shifted;

   // dividend is below divisor, so the quotient of (dividend << 16) fits 16 bits
   always_comb begin
      shifted = {rem_ff, 1'b0};
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = div_req.dividend;
         dsr_in = div_req.divisor;
         cnt_in = 5'd16;
      end else if (cnt_ff != 5'd0) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = 24'(shifted - {1'b0, dsr_ff});
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = shifted[23:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 5'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign div_done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/multi_channel_ramp_hold_fade.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_ramp_hold_fade
// table of envelope channels: linear ramp, optional hold, smoothstep fade
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                                   tuser
//  req_      in   channel, target, current, base, duration, hold_en,  kind
//                 hold, mode, now (184 bits)
//  rsp_      out  out_channel, out_value, out_mode (40 bits)           present
//  csr_      in   fade_ms, written when csr_wr_en is high              -
//
//  a set is written straight from idle; a release one of a live channel that
//  is not fading reads its entry, waits on the progress divider while the ramp
//  runs and writes the fade back; release all and sample walk every channel,
//  skipping an absent one after its read, and a sample also emits a result
//  for each live channel that it reports
//  reset is synchronous; the channel table needs no clearing pass
//  results wait in an output register; one more result is held back so that
//  tlast can be set, and a stalled rsp_ side stalls the channel walk
// ----------------------------------------------------------------------------
module multi_channel_ramp_hold_fade #(
   parameter int NUM_CHANNELS = mrhf_pkg::DEF_NUM_CHANNELS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // channel[3:0] target[35:4] current[67:36] base[99:68] duration[123:100]
   // hold_en[124] hold[148:125] mode[150:149] now[182:151] pad[183]
   input  logic [183:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_channel[3:0] out_value[35:4] out_mode[37:36] pad[39:38]
   output logic [39:0]  rsp_tdata,
   // present[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);
   import mrhf_pkg::*;

   localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CW = $clog2(NUM_CHANNELS + 1);

   // input fields
   logic [3:0]  in_channel;
   logic [31:0] in_target, in_current, in_base, in_now;
   logic [23:0] in_duration, in_hold;
   logic        in_hold_en;
   logic [1:0]  in_mode;
   logic [7:0]  in_chan8;
   logic        in_range, req_xfer;

   assign in_channel  = req_tdata[3:0];
   assign in_target   = req_tdata[35:4];
   assign in_current  = req_tdata[67:36];
   assign in_base     = req_tdata[99:68];
   assign in_duration = req_tdata[123:100];
   assign in_hold_en  = req_tdata[124];
   assign in_hold     = req_tdata[148:125];
   assign in_mode     = req_tdata[150:149];
   assign in_now      = req_tdata[182:151];
   assign in_chan8    = 8'(in_channel);
   assign in_range    = 32'(in_channel) < 32'(NUM_CHANNELS);

   state_type   state_ff, state_in;
   logic [1:0]  kind_ff;
   logic [31:0] now_ff;
   logic [CW-1:0] cnt_ff;
   logic [7:0]  cnt8;
   logic [IW-1:0] cidx;
   logic [4:0]  n_ff;
   logic [15:0] fade_ms_ff;
   logic [NUM_CHANNELS-1:0] valid_ff;

   // channel table
   entry_type mem [NUM_CHANNELS];
   entry_type rd_ff, work_ff, ev, set_entry, rel_entry;
   logic          mem_we;
   logic [IW-1:0] mem_addr;
   entry_type     mem_wd;

   // arithmetic pipeline
   logic [16:0] p_ff;
   logic [32:0] pp_ff;
   logic signed [50:0] prod_ff;
   logic [31:0] val_ff, value;
   logic [33:0] settle;
   logic        fin, drop;

   // progress selection
   logic [31:0] sel_start, sel_from, sel_to;
   logic [23:0] sel_len;
   logic [32:0] elapsed;
   logic signed [32:0] diff;
   logic [17:0] smooth_k;
   logic [50:0] smooth_prod;
   logic signed [50:0] prod_shift;

   div_req_type div_req;
   logic        div_done;
   logic [15:0] quotient;

   // held-back result and output register
   logic        pend_valid_ff;
   logic [3:0]  pend_chan_ff;
   logic [31:0] pend_value_ff;
   logic [1:0]  pend_mode_ff;
   logic        rsp_valid_ff, rsp_valid_in, rsp_present_ff, rsp_last_ff;
   logic [3:0]  rsp_chan_ff;
   logic [31:0] rsp_value_ff;
   logic [1:0]  rsp_mode_ff;
   logic        slot_free;

   assign cnt8      = 8'(cnt_ff);
   assign cidx      = cnt_ff[IW-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer  = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // output register: drains on a transfer, loads when a result moves in
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (state_ff == S_EMIT && pend_valid_ff && slot_free) begin
         rsp_valid_in = 1'b1;
      end
      if (state_ff == S_FINAL && slot_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // hold expiry and end of fade, seen on the entry just read
   always_comb begin
      ev     = rd_ff;
      settle = 34'(rd_ff.ramp_start) + 34'(rd_ff.ramp_len) + 34'(rd_ff.hold_len);
      if (kind_ff == KIND_SAMPLE && !rd_ff.fading && rd_ff.hold_on
          && 34'(now_ff) >= settle) begin
         ev.fading     = 1'b1;
         ev.fade_start = settle[31:0];
         ev.fade_from  = rd_ff.ramp_to;
      end
      fin  = ev.fading && (33'(now_ff) >= 33'(ev.fade_start) + 33'(fade_ms_ff));
      drop = fin && ev.done_once;
      if (fin) begin
         ev.done_once = 1'b1;
      end
   end

   // operands of the value of the channel in work
   always_comb begin
      if (work_ff.fading) begin
         sel_start = work_ff.fade_start;
         sel_len   = 24'(fade_ms_ff);
         sel_from  = work_ff.fade_from;
         sel_to    = work_ff.rest_value;
      end else begin
         sel_start = work_ff.ramp_start;
         sel_len   = work_ff.ramp_len;
         sel_from  = work_ff.ramp_from;
         sel_to    = work_ff.ramp_to;
      end
      elapsed     = 33'(now_ff) - 33'(sel_start);
      diff        = $signed({sel_to[31], sel_to}) - $signed({sel_from[31], sel_from});
      smooth_k    = SMOOTH_K - {p_ff, 1'b0};
      smooth_prod = 51'(pp_ff) * 51'(smooth_k);
      prod_shift  = prod_ff >>> 16;
      value       = sel_from + prod_shift[31:0];
   end

   always_comb begin
      set_entry            = '0;
      set_entry.ramp_from  = in_current;
      set_entry.ramp_to    = in_target;
      set_entry.ramp_start = in_now;
      set_entry.ramp_len   = in_duration;
      set_entry.hold_on    = in_hold_en;
      set_entry.hold_len   = in_hold;
      set_entry.rest_value = in_base;
      set_entry.chan_mode  = in_mode;
      rel_entry            = work_ff;
      rel_entry.fading     = 1'b1;
      rel_entry.fade_start = now_ff;
      rel_entry.fade_from  = value;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_tuser == KIND_RELEASE_ALL || req_tuser == KIND_SAMPLE) begin
                  state_in = S_READ;
               end else if (req_tuser == KIND_RELEASE_ONE && in_range) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            if (!valid_ff[cidx]) begin
               state_in = S_NEXT;
            end else if (kind_ff == KIND_SAMPLE) begin
               if (drop || n_ff >= 5'(MAX_RESULTS)) begin
                  state_in = S_NEXT;
               end else begin
                  state_in = S_CALC;
               end
            end else if (rd_ff.fading) begin
               state_in = S_NEXT;
            end else begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (sel_len == 24'd0 || elapsed[32] || elapsed == 33'd0
                || elapsed[31:0] >= 32'(sel_len)) begin
               state_in = work_ff.fading ? S_SQ : S_MUL;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = work_ff.fading ? S_SQ : S_MUL;
            end
         end
         S_SQ:  state_in = S_SM;
         S_SM:  state_in = S_MUL;
         S_MUL: state_in = S_ADD;
         S_ADD: state_in = (kind_ff == KIND_SAMPLE) ? S_EMIT : S_NEXT;
         S_EMIT: begin
            if (!pend_valid_ff || slot_free) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (kind_ff == KIND_RELEASE_ONE) begin
               state_in = S_IDLE;
            end else if (cnt_ff == CW'(NUM_CHANNELS - 1)) begin
               state_in = (kind_ff == KIND_SAMPLE) ? S_FINAL : S_IDLE;
            end else begin
               state_in = S_READ;
            end
         end
         S_FINAL: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // table writes and divider start
   always_comb begin
      mem_we   = 1'b0;
      mem_addr = cidx;
      mem_wd   = ev;
      div_req  = '0;
      div_req.dividend = elapsed[23:0];
      div_req.divisor  = sel_len;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_tuser == KIND_SET && in_range) begin
               mem_we   = 1'b1;
               mem_addr = in_chan8[IW-1:0];
               mem_wd   = set_entry;
            end
         end
         S_EVAL: begin
            mem_we = (kind_ff == KIND_SAMPLE) && valid_ff[cidx] && !drop;
         end
         S_CALC: begin
            div_req.start = (state_in == S_DIV);
         end
         S_ADD: begin
            if (kind_ff != KIND_SAMPLE) begin
               mem_we = 1'b1;
               mem_wd = rel_entry;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      rd_ff <= mem[cidx];
   end

   mrhf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .quotient (quotient)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fade_ms_ff    <= FADE_MS_RESET;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         n_ff          <= 5'd0;
         kind_ff       <= KIND_SET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            fade_ms_ff <= csr_wr_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  kind_ff <= req_tuser;
                  n_ff    <= 5'd0;
                  if (req_tuser == KIND_SET && in_range) begin
                     valid_ff[in_chan8[IW-1:0]] <= 1'b1;
                  end
                  if (req_tuser == KIND_RELEASE_ONE) begin
                     cnt_ff <= CW'(in_channel);
                  end else begin
                     cnt_ff <= '0;
                  end
               end
            end
            S_EVAL: begin
               if (kind_ff == KIND_SAMPLE && valid_ff[cidx] && drop) begin
                  valid_ff[cidx] <= 1'b0;
               end
            end
            S_EMIT: begin
               if (!pend_valid_ff || slot_free) begin
                  pend_valid_ff <= 1'b1;
                  n_ff          <= n_ff + 5'd1;
               end
            end
            S_NEXT: begin
               cnt_ff <= cnt_ff + CW'(1);
            end
            S_FINAL: begin
               if (slot_free) begin
                  pend_valid_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               now_ff <= in_now;
            end
         end
         S_EVAL: work_ff <= ev;
         S_CALC: begin
            if (sel_len == 24'd0 || elapsed[32] == 1'b0 && elapsed != 33'd0
                && elapsed[31:0] >= 32'(sel_len)) begin
               p_ff <= ONE_Q16;
            end else begin
               p_ff <= 17'd0;
            end
         end
         S_DIV: begin
            if (div_done) begin
               p_ff <= 17'(quotient);
            end
         end
         S_SQ:  pp_ff   <= 33'(p_ff) * 33'(p_ff);
         S_SM:  p_ff    <= smooth_prod[48:32];
         S_MUL: prod_ff <= diff * $signed({1'b0, p_ff});
         S_ADD: val_ff  <= value;
         S_EMIT: begin
            if (!pend_valid_ff || slot_free) begin
               if (pend_valid_ff) begin
                  // older result leaves, not the last of this sample
                  rsp_present_ff <= 1'b1;
                  rsp_chan_ff    <= pend_chan_ff;
                  rsp_value_ff   <= pend_value_ff;
                  rsp_mode_ff    <= pend_mode_ff;
                  rsp_last_ff    <= 1'b0;
               end
               pend_chan_ff   <= cnt8[3:0];
               pend_value_ff  <= val_ff;
               pend_mode_ff   <= work_ff.chan_mode;
            end
         end
         S_FINAL: begin
            if (slot_free) begin
               // held result closes the sample, or the empty-table marker
               rsp_present_ff <= pend_valid_ff;
               rsp_chan_ff    <= pend_valid_ff ? pend_chan_ff : 4'd0;
               rsp_value_ff   <= pend_valid_ff ? pend_value_ff : 32'd0;
               rsp_mode_ff    <= pend_valid_ff ? pend_mode_ff : 2'd0;
               rsp_last_ff    <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_mode_ff, rsp_value_ff, rsp_chan_ff};
   assign rsp_tuser  = rsp_present_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sim/multi_channel_ramp_hold_fade_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_ramp_hold_fade_tb
// self-checking bench for the ramp / hold / fade channel table: a queue-fed
// driver offers set, release and sample transfers with random gaps, a
// behavioral copy of the channel table predicts every sample result, and a
// monitor compares each result transfer field by field in order
// ----------------------------------------------------------------------------
module multi_channel_ramp_hold_fade_tb;
   import mrhf_pkg::*;

   localparam int NCH        = 16;
   // worst-case walk of a sample or release all, with margin
   localparam int SETTLE_CYC = 600;

   typedef struct {
      bit          is_ctl;     // control marker: wait for idle, maybe write fade
      bit          do_write;
      logic [15:0] fade_val;
      logic [1:0]  kind;
      logic [3:0]  channel;
      logic [31:0] target;
      logic [31:0] current;
      logic [31:0] base;
      logic [23:0] duration;
      logic        hold_en;
      logic [23:0] hold;
      logic [1:0]  mode;
      logic [31:0] now;
   } req_item_t;

   typedef struct {
      logic        present;
      logic [3:0]  channel;
      logic [31:0] value;
      logic [1:0]  mode;
      logic        last;
   } sample_out_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [183:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wr_en = 1'b0;
   logic [15:0]  csr_wr_data = '0;

   req_item_t   pending_reqs[$];
   sample_out_t predicted_samples[$];
   int          error_count = 0;

   // behavioral copy of the channel table
   longint      env_fade_len;
   bit          env_valid[NCH];
   longint      env_from[NCH], env_to[NCH], env_rest[NCH], env_fade_from[NCH];
   int unsigned env_start[NCH], env_len[NCH], env_hold_len[NCH], env_fade_start[NCH];
   bit          env_hold[NCH], env_fading[NCH], env_done[NCH];
   logic [1:0]  env_mode[NCH];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   multi_channel_ramp_hold_fade u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------- predictor
   function automatic longint progress_q16(int unsigned now, int unsigned start, longint len);
      longint el;
      el = longint'({32'd0, now}) - longint'({32'd0, start});
      if (len == 0) return 65536;
      if (el <= 0) return 0;
      if (el >= len) return 65536;
      return (el <<< 16) / len;
   endfunction

   function automatic longint smoothstep_q16(longint p);
      return (p * p * (196608 - 2 * p)) >>> 32;
   endfunction

   // floor interpolation, arithmetic shift gives the floor for negative spans
   function automatic longint lerp_q16(longint from, longint to, longint p);
      return from + (((to - from) * p) >>> 16);
   endfunction

   function automatic longint channel_value(int c, int unsigned now);
      if (env_fading[c])
         return lerp_q16(env_fade_from[c], env_rest[c],
                         smoothstep_q16(progress_q16(now, env_fade_start[c], env_fade_len)));
      return lerp_q16(env_from[c], env_to[c], progress_q16(now, env_start[c], env_len[c]));
   endfunction

   function automatic void start_fade(int c, int unsigned now);
      if (!env_valid[c] || env_fading[c]) return;
      env_fade_from[c]  = channel_value(c, now);
      env_fade_start[c] = now;
      env_fading[c]     = 1'b1;
   endfunction

   function automatic void apply_envelope_req(req_item_t it);
      sample_out_t outs[$];
      sample_out_t r;
      longint      settle;
      bit          finished;
      int          c;
      case (it.kind)
         KIND_SET: begin
            c = it.channel;
            env_valid[c]      = 1'b1;
            env_to[c]         = longint'($signed(it.target));
            env_from[c]       = longint'($signed(it.current));
            env_rest[c]       = longint'($signed(it.base));
            env_len[c]        = it.duration;
            env_hold[c]       = it.hold_en;
            env_hold_len[c]   = it.hold;
            env_mode[c]       = it.mode;
            env_start[c]      = it.now;
            env_fading[c]     = 1'b0;
            env_fade_start[c] = 0;
            env_fade_from[c]  = 0;
            env_done[c]       = 1'b0;
         end
         KIND_RELEASE_ONE: start_fade(it.channel, it.now);
         KIND_RELEASE_ALL: for (c = 0; c < NCH; c++) start_fade(c, it.now);
         default: begin
            for (c = 0; c < NCH; c++) begin
               if (env_valid[c]) begin
                  if (!env_fading[c] && env_hold[c]) begin
                     settle = longint'({32'd0, env_start[c]}) + env_len[c] + env_hold_len[c];
                     if (longint'({32'd0, it.now}) >= settle) begin
                        env_fade_from[c]  = env_to[c];
                        env_fade_start[c] = settle[31:0];
                        env_fading[c]     = 1'b1;
                     end
                  end
                  finished = env_fading[c] && (longint'({32'd0, it.now}) >=
                             longint'({32'd0, env_fade_start[c]}) + env_fade_len);
                  if (finished && env_done[c]) env_valid[c] = 1'b0;
                  else begin
                     if (finished) env_done[c] = 1'b1;
                     r.present = 1'b1;
                     r.channel = c[3:0];
                     r.value   = 32'(channel_value(c, it.now));
                     r.mode    = env_mode[c];
                     r.last    = 1'b0;
                     outs.insert(outs.size(), r);
                  end
               end
            end
            if (outs.size() == 0) begin
               r = '{1'b0, 4'd0, 32'd0, 2'd0, 1'b1};
               outs.insert(outs.size(), r);
            end
            outs[outs.size() - 1].last = 1'b1;
            foreach (outs[i]) predicted_samples.insert(predicted_samples.size(), outs[i]);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- driver
   logic      req_fire = 1'b0;
   logic      rsp_fire = 1'b0;
   int        req_gap = 0;
   int        idle_cnt = 0;
   int        items_sent = 0;
   bit        feed_done = 1'b0;
   req_item_t head;
   logic      nxt_valid, nxt_wr;

   always @(negedge clock) begin
      nxt_valid = req_tvalid;
      nxt_wr    = 1'b0;
      if (!reset && !(req_tvalid && !req_fire)) begin
         nxt_valid = 1'b0;
         if (req_gap > 0) req_gap--;
         else if (pending_reqs.size() > 0) begin
            head = pending_reqs[0];
            if (head.is_ctl) begin
               // release and set give no result, so let the walk drain as well
               if (predicted_samples.size() == 0) idle_cnt++;
               else idle_cnt = 0;
               if (idle_cnt >= SETTLE_CYC) begin
                  nxt_wr      = head.do_write;
                  csr_wr_data <= head.fade_val;
                  idle_cnt    = 0;
                  void'(pending_reqs.pop_front());
               end
            end else begin
               req_tdata <= {1'b0, head.now, head.mode, head.hold, head.hold_en,
                             head.duration, head.base, head.current, head.target,
                             head.channel};
               req_tuser <= head.kind;
               nxt_valid = 1'b1;
               void'(pending_reqs.pop_front());
               items_sent++;
               // bursts without gaps every other stretch of 40 transfers
               req_gap = ((items_sent / 40) % 2 == 1) ? 0 : $urandom_range(0, 8);
            end
         end else feed_done = 1'b1;
      end
      req_tvalid <= nxt_valid;
      csr_wr_en  <= nxt_wr;
   end

   // ---------------------------------------------------------------- receiver
   int rsp_wait = 0;
   int rsp_count = 0;
   int long_stall = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) begin
            rsp_wait = $urandom_range(0, 8);
            // one long hold-off so the table walk backs up into the request side
            if (rsp_count == 60) long_stall = 3000;
         end else if (long_stall > 0) long_stall--;
         else if (rsp_wait > 0) rsp_wait--;
         rsp_tready <= (long_stall == 0 && rsp_wait == 0);
      end
   end

   // ---------------------------------------------------------------- monitor
   sample_out_t want;

   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
      rsp_fire <= !reset && rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (csr_wr_en) env_fade_len = csr_wr_data;
         if (req_tvalid && req_tready)
            apply_envelope_req('{1'b0, 1'b0, 16'd0, req_tuser, req_tdata[3:0],
                                 req_tdata[35:4], req_tdata[67:36], req_tdata[99:68],
                                 req_tdata[123:100], req_tdata[124], req_tdata[148:125],
                                 req_tdata[150:149], req_tdata[182:151]});
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (predicted_samples.size() == 0) begin
               $error("unexpected result transfer: channel %0d", rsp_tdata[3:0]);
               error_count++;
            end else begin
               want = predicted_samples.pop_front();
               if (rsp_tuser !== want.present) begin
                  $error("present: expected %0d, got %0d", want.present, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[3:0] !== want.channel) begin
                  $error("out_channel: expected %0d, got %0d", want.channel, rsp_tdata[3:0]);
                  error_count++;
               end
               if (rsp_tdata[35:4] !== want.value) begin
                  $error("out_value: expected %h, got %h", want.value, rsp_tdata[35:4]);
                  error_count++;
               end
               if (rsp_tdata[37:36] !== want.mode) begin
                  $error("out_mode: expected %0d, got %0d", want.mode, rsp_tdata[37:36]);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   int unsigned clk_ms = 0;

   function automatic req_item_t make_req(logic [1:0] kind, logic [3:0] ch, int unsigned now);
      req_item_t it;
      it = '{default: '0};
      it.kind = kind;
      it.channel = ch;
      it.now = now;
      return it;
   endfunction

   task automatic queue_req(req_item_t it);
      pending_reqs.insert(pending_reqs.size(), it);
   endtask

   task automatic add_set(logic [3:0] ch, logic [31:0] tgt, logic [31:0] cur,
                          logic [31:0] bas, logic [23:0] dur, logic hen,
                          logic [23:0] hld, logic [1:0] md, int unsigned now);
      req_item_t it;
      it = make_req(KIND_SET, ch, now);
      it.target = tgt; it.current = cur; it.base = bas;
      it.duration = dur; it.hold_en = hen; it.hold = hld; it.mode = md;
      queue_req(it);
   endtask

   task automatic add_ctl(bit wr, logic [15:0] val);
      req_item_t it;
      it = '{default: '0};
      it.is_ctl = 1'b1; it.do_write = wr; it.fade_val = val;
      queue_req(it);
   endtask

   task automatic add_random(int count);
      req_item_t it;
      int        sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if ($urandom_range(0, 30) == 0) clk_ms = $urandom();
         else if ($urandom_range(0, 15) == 0) clk_ms -= $urandom_range(0, 100);
         else clk_ms += $urandom_range(0, 300);
         it = make_req(KIND_SAMPLE, 4'($urandom_range(0, 15)), clk_ms);
         if (sel < 30) begin
            it.kind = KIND_SET;
            it.target  = ($urandom_range(0, 1)) ? $urandom() : 32'($urandom_range(0, 2000000));
            it.current = ($urandom_range(0, 1)) ? $urandom() : -32'($urandom_range(0, 2000000));
            it.base    = $urandom();
            it.duration = ($urandom_range(0, 9) == 0) ? 24'($urandom()) :
                          24'($urandom_range(0, 1500));
            it.hold_en = 1'($urandom_range(0, 1));
            it.hold    = ($urandom_range(0, 9) == 0) ? 24'($urandom()) :
                         24'($urandom_range(0, 1000));
            it.mode    = 2'($urandom_range(0, 3));
         end else if (sel < 45) it.kind = KIND_RELEASE_ONE;
         else if (sel < 50) it.kind = KIND_RELEASE_ALL;
         queue_req(it);
      end
   endtask

   initial begin
      env_fade_len = FADE_MS_RESET;
      foreach (env_valid[i]) env_valid[i] = 1'b0;

      // directed: empty table, extreme values, zero and maximal ramp lengths
      queue_req(make_req(KIND_SAMPLE, 4'd0, 0));
      add_set(4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 24'd0, 1'b0, 24'd0, 2'd0, 10);
      add_set(4'd15, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd1000, 1'b1,
              24'd200, 2'd3, 20);
      add_set(4'd5, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 24'hFF_FFFF, 1'b0,
              24'hFF_FFFF, 2'd2, 30);
      queue_req(make_req(KIND_SAMPLE, 4'd0, 520));
      queue_req(make_req(KIND_RELEASE_ONE, 4'd5, 600));
      // a fading channel and an absent channel are left alone
      queue_req(make_req(KIND_RELEASE_ONE, 4'd5, 700));
      queue_req(make_req(KIND_RELEASE_ONE, 4'd3, 700));
      queue_req(make_req(KIND_SAMPLE, 4'd0, 850));
      // time going backwards
      queue_req(make_req(KIND_SAMPLE, 4'd0, 5));
      queue_req(make_req(KIND_SAMPLE, 4'd0, 1300));
      queue_req(make_req(KIND_RELEASE_ALL, 4'd0, 1400));
      // overwrite a live fading channel
      add_set(4'd5, 32'h0010_0000, 32'hFFF0_0000, 32'h0, 24'd100, 1'b1, 24'd0, 2'd1, 1500);
      queue_req(make_req(KIND_SAMPLE, 4'd0, 1650));
      // fades end, each channel is reported once more and then removed
      queue_req(make_req(KIND_SAMPLE, 4'd0, 3000));
      queue_req(make_req(KIND_SAMPLE, 4'd0, 3001));
      // hold end past the 32-bit clock never triggers
      add_set(4'd9, 32'h1234_5678, 32'h0, 32'h0, 24'hFF_FFFF, 1'b1, 24'hFF_FFFF,
              2'd1, 32'hFFFF_0000);
      queue_req(make_req(KIND_SAMPLE, 4'd0, 32'hFFFF_FFFF));
      queue_req(make_req(KIND_RELEASE_ALL, 4'd0, 32'hFFFF_FFF0));
      queue_req(make_req(KIND_SAMPLE, 4'd0, 32'hFFFF_FFFF));

      // random phases over several fade lengths, the extremes among them
      clk_ms = 4000;
      add_ctl(1'b0, 16'd0);
      add_random(90);
      add_ctl(1'b1, 16'd0);
      add_random(90);
      add_ctl(1'b1, 16'hFFFF);
      add_random(90);
      add_ctl(1'b1, 16'($urandom_range(1, 1000)));
      add_random(90);
      add_ctl(1'b1, 16'($urandom()));
      add_random(90);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (feed_done && predicted_samples.size() == 0);
      repeat (SETTLE_CYC) @(posedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #40ms;
      $display("FAILURE");
      $finish;
   end

endmodule
